// ----- rtl/qmr_pkg.sv -----
// ----------------------------------------------------------------------------
// qmr_pkg
// types, widths and the sign table shared by the quaternion multiply/rotate unit
// ----------------------------------------------------------------------------
package qmr_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC       = DATA_WIDTH - 3;
    localparam int PW         = 2 * DATA_WIDTH;      // one raw product
    localparam int SW         = PW + 3;              // sum of four products plus rounding

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef t_data [3:0] t_quat;                     // [0] = w, [1] = x, [2] = y, [3] = z
    typedef logic signed [PW-1:0] t_prod;
    typedef t_prod [15:0] t_prods;                   // index {i, j} = x[i] * y[j]

    // component k, term n uses x[n] * y[k ^ n]; bit {k, n} set means subtract
    localparam logic [15:0] NEG_MASK = 16'b0100_0010_1000_1110;

    localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] MINV = SW'(-(64'sd1 <<< (DATA_WIDTH - 1)));
    localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (FRAC - 1));

    typedef enum logic {
        CMD_PRODUCT = 1'b0,
        CMD_ROTATE  = 1'b1
    } t_cmd;

    // sideband that travels with each item through the pipe
    typedef struct packed {
        t_cmd  cmd;
        logic  sat;
        t_quat a;      // first operand, kept for the conjugate pass
        t_quat t;      // result of the last sum stage
    } t_side;

    typedef struct packed {
        logic  command;
        t_data a_w;
        t_data a_x;
        t_data a_y;
        t_data a_z;
        t_data b_w;
        t_data b_x;
        t_data b_y;
        t_data b_z;
    } t_in;

    typedef struct packed {
        t_data r_w;
        t_data r_x;
        t_data r_y;
        t_data r_z;
        logic  saturated;
    } t_out;

endpackage

// ----- rtl/qmr_mul.sv -----
// ----------------------------------------------------------------------------
// qmr_mul
// pipeline stage forming all sixteen products x[i] * y[j]
// ----------------------------------------------------------------------------
module qmr_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qmr_pkg::t_quat i_x,
    input  qmr_pkg::t_quat i_y,
    input  qmr_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output qmr_pkg::t_prods o_prod,
    output qmr_pkg::t_side o_side
);
    import qmr_pkg::*;

    logic   r_valid;
    t_prods r_prod;
    t_side  r_side;
    t_prods n_prod;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_prod[i * 4 + j] = PW'($signed(i_x[i])) * PW'($signed(i_y[j]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod <= n_prod;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_side  = r_side;

endmodule

// ----- rtl/qmr_sum.sv -----
// ----------------------------------------------------------------------------
// qmr_sum
// pipeline stage: signed sum of four products per component, round, saturate
// ----------------------------------------------------------------------------
module qmr_sum #(
    parameter bit LAST = 1'b0    // second pass: conjugate operand, final select
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qmr_pkg::t_prods i_prod,
    input  qmr_pkg::t_side  i_side,
    output logic            o_valid,
    input  logic            i_ready,
    output qmr_pkg::t_side  o_side
);
    import qmr_pkg::*;

    logic signed [SW-1:0] sum [4];
    logic signed [SW-1:0] rnd [4];
    t_quat                res;
    logic [3:0]           flg;
    logic                 r_valid;
    t_side                r_side;
    t_side                n_side;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] term;
        logic [1:0]           jj;
        logic                 neg;
        for (int k = 0; k < 4; k++) begin
            acc = '0;
            for (int n = 0; n < 4; n++) begin
                jj   = 2'(k) ^ 2'(n);
                term = SW'($signed(i_prod[{2'(n), jj}]));
                // conjugate pass negates every vector part of the second operand
                neg  = NEG_MASK[{2'(k), 2'(n)}] ^ (LAST && (jj != 2'd0));
                acc  = neg ? acc - term : acc + term;
            end
            sum[k] = acc;
            rnd[k] = (sum[k] + HALF) >>> FRAC;
            if (rnd[k] > MAXV) begin
                res[k] = MAXV[DATA_WIDTH-1:0];
                flg[k] = 1'b1;
            end else if (rnd[k] < MINV) begin
                res[k] = MINV[DATA_WIDTH-1:0];
                flg[k] = 1'b1;
            end else begin
                res[k] = rnd[k][DATA_WIDTH-1:0];
                flg[k] = 1'b0;
            end
        end
    end

    always_comb begin
        n_side = i_side;
        if (!LAST) begin
            n_side.t   = res;
            n_side.sat = |flg;
        end else if (i_side.cmd == CMD_ROTATE) begin
            // rotated vector, scalar part not formed
            n_side.t[0] = '0;
            n_side.t[1] = res[1];
            n_side.t[2] = res[2];
            n_side.t[3] = res[3];
            n_side.sat  = i_side.sat | flg[1] | flg[2] | flg[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;

endmodule

// ----- rtl/quaternion_multiply_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate
// fixed-point Q2.13 Hamilton product a*b, or rotation a*p*conj(a) of vector b
// ----------------------------------------------------------------------------
//
//  channel | valid       | ready       | payload     | direction
//  --------+-------------+-------------+-------------+-----------
//  input   | i_in_valid  | o_in_ready  | i_in_data   | in
//  result  | o_out_valid | i_out_ready | o_out_data  | out
//
//  one beat per cycle sustained unless the result channel stalls; the register
//  stages in order are multiply, sum/round, multiply, sum/round
//  each stage holds its own valid bit and loads whenever it is empty or its
//  successor takes its beat, so bubbles collapse and a stall loses nothing
//  synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qmr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qmr_pkg::t_out o_out_data
);
    import qmr_pkg::*;

    // stage 1 operands
    t_quat  s1_x;
    t_quat  s1_y;
    t_side  s1_side;

    // stage handshakes
    logic   m1_valid, m1_ready;
    t_prods m1_prod;
    t_side  m1_side;

    logic   a1_valid, a1_ready;
    t_side  a1_side;

    logic   m2_valid, m2_ready;
    t_prods m2_prod;
    t_side  m2_side;

    logic   a2_valid;
    t_side  a2_side;

    // first pass: a*b, or a*p with p = (0, b_x, b_y, b_z) when rotating
    always_comb begin
        s1_x[0] = i_in_data.a_w;
        s1_x[1] = i_in_data.a_x;
        s1_x[2] = i_in_data.a_y;
        s1_x[3] = i_in_data.a_z;
        s1_y[0] = (t_cmd'(i_in_data.command) == CMD_ROTATE) ? '0 : i_in_data.b_w;
        s1_y[1] = i_in_data.b_x;
        s1_y[2] = i_in_data.b_y;
        s1_y[3] = i_in_data.b_z;
        s1_side.cmd = t_cmd'(i_in_data.command);
        s1_side.sat = 1'b0;
        s1_side.a   = s1_x;
        s1_side.t   = '0;
    end

    qmr_mul u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (s1_x),
        .i_y     (s1_y),
        .i_side  (s1_side),
        .o_valid (m1_valid),
        .i_ready (m1_ready),
        .o_prod  (m1_prod),
        .o_side  (m1_side)
    );

    // first pass round and saturate; result lands in side.t
    qmr_sum #(.LAST(1'b0)) u_sum1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m1_valid),
        .o_ready (m1_ready),
        .i_prod  (m1_prod),
        .i_side  (m1_side),
        .o_valid (a1_valid),
        .i_ready (a1_ready),
        .o_side  (a1_side)
    );

    // second pass: t * conj(a); sign flips of conj are folded into the sum stage
    qmr_mul u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (a1_valid),
        .o_ready (a1_ready),
        .i_x     (a1_side.t),
        .i_y     (a1_side.a),
        .i_side  (a1_side),
        .o_valid (m2_valid),
        .i_ready (m2_ready),
        .o_prod  (m2_prod),
        .o_side  (m2_side)
    );

    // product beats keep their first-pass result, rotate beats take the new one
    qmr_sum #(.LAST(1'b1)) u_sum2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m2_valid),
        .o_ready (m2_ready),
        .i_prod  (m2_prod),
        .i_side  (m2_side),
        .o_valid (a2_valid),
        .i_ready (i_out_ready),
        .o_side  (a2_side)
    );

    assign o_out_valid          = a2_valid;
    assign o_out_data.r_w       = a2_side.t[0];
    assign o_out_data.r_x       = a2_side.t[1];
    assign o_out_data.r_y       = a2_side.t[2];
    assign o_out_data.r_z       = a2_side.t[3];
    assign o_out_data.saturated = a2_side.sat;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks quaternion_multiply_rotate beat by beat against a fixed-point
// predictor of the Hamilton product and the a*p*conj(a) rotation, with
// random idling and stalls on both channels
// ----------------------------------------------------------------------------
module testbench;

    import qmr_pkg::*;

    // fixed-point landmarks in Q2.13
    localparam int Q_ONE       = 1 << FRAC;
    localparam int Q_MAX       = (1 << (DATA_WIDTH - 1)) - 1;
    localparam int Q_MIN       = -(1 << (DATA_WIDTH - 1));
    localparam int Q_COS45     = 5793;           // cos(45 deg) rounded
    localparam int IDLE_PCT    = 12;
    localparam int DRAIN_TAIL  = 16;             // slack after the last predicted result is back
    localparam int STALL_LIMIT = 4000;           // cycles with no beat on either side

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    t_out pending_results[$];      // predicted results, oldest first
    int   error_count  = 0;
    int   stall_cycles = 0;
    bit   tx_steady    = 1'b0;     // sender never idles while set
    bit   rx_steady    = 1'b0;     // receiver never stalls while set

    quaternion_multiply_rotate u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // exact sum in units of 2^-2F -> round half up -> clamp to the data range
    function automatic longint round_clamp(input longint sum, output bit clamped);
        longint hi_lim;
        longint lo_lim;
        longint v;
        hi_lim  = Q_MAX;
        lo_lim  = Q_MIN;
        v       = (sum + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        clamped = 1'b0;
        if (v > hi_lim) begin
            clamped = 1'b1;
            v       = hi_lim;
        end else if (v < lo_lim) begin
            clamped = 1'b1;
            v       = lo_lim;
        end
        return v;
    endfunction

    // r = x*y, returns one clamp flag per component (w, x, y, z)
    function automatic logic [3:0] hamilton(input longint x[4], input longint y[4],
                                            output longint r[4]);
        bit c0, c1, c2, c3;
        r[0] = round_clamp(x[0]*y[0] - x[1]*y[1] - x[2]*y[2] - x[3]*y[3], c0);
        r[1] = round_clamp(x[0]*y[1] + x[1]*y[0] + x[2]*y[3] - x[3]*y[2], c1);
        r[2] = round_clamp(x[0]*y[2] - x[1]*y[3] + x[2]*y[0] + x[3]*y[1], c2);
        r[3] = round_clamp(x[0]*y[3] + x[1]*y[2] - x[2]*y[1] + x[3]*y[0], c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic t_out predict_result(input t_in beat);
        longint     a[4], b[4], mid[4], conj[4], r[4];
        logic [3:0] clip_first;
        logic [3:0] clip_second;
        t_out       res;
        a[0] = beat.a_w; a[1] = beat.a_x; a[2] = beat.a_y; a[3] = beat.a_z;
        b[0] = beat.b_w; b[1] = beat.b_x; b[2] = beat.b_y; b[3] = beat.b_z;
        if (beat.command == CMD_PRODUCT) begin
            clip_first    = hamilton(a, b, r);
            res.saturated = |clip_first;
        end else begin
            // pure quaternion, b_w plays no part
            b[0]       = 0;
            clip_first = hamilton(a, b, mid);
            // conjugate negated exactly, -(-32768) stays 32768
            conj[0] = a[0]; conj[1] = -a[1]; conj[2] = -a[2]; conj[3] = -a[3];
            clip_second   = hamilton(mid, conj, r);
            // scalar of the second pass is never formed, so its flag is dropped
            r[0]          = 0;
            res.saturated = (|clip_first) || (|clip_second[3:1]);
        end
        res.r_w = t_data'(r[0]);
        res.r_x = t_data'(r[1]);
        res.r_y = t_data'(r[2]);
        res.r_z = t_data'(r[3]);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // scoreboard: expectation pushed on every accepted input beat, popped and
    // compared on every accepted result beat
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input longint expv, input longint actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, o_out_data);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("r_w", want.r_w, o_out_data.r_w);
                    compare_field("r_x", want.r_x, o_out_data.r_x);
                    compare_field("r_y", want.r_y, o_out_data.r_y);
                    compare_field("r_z", want.r_z, o_out_data.r_z);
                    compare_field("saturated", want.saturated, o_out_data.saturated);
                end
            end
            if (i_in_valid && o_in_ready)
                pending_results.push_back(predict_result(i_in_data));
        end
    end

    // receiver: stalls about 12 beats in a hundred unless in a steady stretch
    always @(posedge i_clk) begin
        i_out_ready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog: any accepted beat on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // drive one beat, idling first at random, return at the edge it is taken
    task automatic send_beat(input t_in beat);
        while (!tx_steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // hold off the sender until every predicted result has come back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        // let the scoreboard record the beat taken at this edge first
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    function automatic t_in make_beat(input t_cmd cmd,
                                      input int aw, input int ax, input int ay, input int az,
                                      input int bw, input int bx, input int by, input int bz);
        t_in beat;
        beat.command = cmd;
        beat.a_w = t_data'(aw); beat.a_x = t_data'(ax);
        beat.a_y = t_data'(ay); beat.a_z = t_data'(az);
        beat.b_w = t_data'(bw); beat.b_x = t_data'(bx);
        beat.b_y = t_data'(by); beat.b_z = t_data'(bz);
        return beat;
    endfunction

    // 0: any bit pattern, 1: within +/-1.0 (rarely clamps), 2: range edges
    function automatic int random_component(input int kind);
        int pick;
        case (kind)
            0: return int'(t_data'($urandom));
            1: return int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
            default: begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 0;
                    3: return 1;
                    4: return -1;
                    default: return Q_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic t_in random_beat();
        int   mix;
        int   kind;
        int   v[8];
        t_cmd cmd;
        mix  = $urandom_range(0, 99);
        kind = (mix < 25) ? 0 : (mix < 80) ? 1 : (mix < 90) ? 2 : 3;
        for (int k = 0; k < 8; k++)
            v[k] = random_component((kind == 3) ? $urandom_range(0, 2) : kind);
        cmd = $urandom_range(0, 1) ? CMD_ROTATE : CMD_PRODUCT;
        return make_beat(cmd, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_directed_product();
        send_beat(make_beat(CMD_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
        // identity on the left
        send_beat(make_beat(CMD_PRODUCT, Q_ONE, 0, 0, 0, 1234, -2000, 300, -7));
        // i*i = -1, i*j = k, j*k = i, k*i = j
        send_beat(make_beat(CMD_PRODUCT, 0, Q_ONE, 0, 0, 0, Q_ONE, 0, 0));
        send_beat(make_beat(CMD_PRODUCT, 0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0));
        send_beat(make_beat(CMD_PRODUCT, 0, 0, Q_ONE, 0, 0, 0, 0, Q_ONE));
        send_beat(make_beat(CMD_PRODUCT, 0, 0, 0, Q_ONE, 0, Q_ONE, 0, 0));
        // full-scale operands, clamping both ways
        send_beat(make_beat(CMD_PRODUCT, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                            Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_beat(make_beat(CMD_PRODUCT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                            Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_beat(make_beat(CMD_PRODUCT, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                            Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        // exact half ulp ties: +0.5 rounds up, -0.5 rounds to zero
        send_beat(make_beat(CMD_PRODUCT, 1, 0, 0, 0, Q_ONE / 2, 0, 0, 0));
        send_beat(make_beat(CMD_PRODUCT, -1, 0, 0, 0, Q_ONE / 2, 0, 0, 0));
        // sitting on each bound, and one step past the upper one
        send_beat(make_beat(CMD_PRODUCT, Q_MIN, 0, 0, 0, Q_ONE, 0, 0, 0));
        send_beat(make_beat(CMD_PRODUCT, Q_MAX, 0, 0, 0, Q_ONE, 0, 0, 0));
        send_beat(make_beat(CMD_PRODUCT, 2 * Q_ONE, 0, 0, 0, 2 * Q_ONE, 0, 0, 0));
    endtask

    task automatic test_directed_rotate();
        // identity rotation, b_w must be ignored
        send_beat(make_beat(CMD_ROTATE, Q_ONE, 0, 0, 0, 777, 1000, -2000, 3000));
        // 90 deg about z
        send_beat(make_beat(CMD_ROTATE, Q_COS45, 0, 0, Q_COS45, -5, Q_ONE, 0, 0));
        // 180 deg about x
        send_beat(make_beat(CMD_ROTATE, 0, Q_ONE, 0, 0, 0, 100, 200, 300));
        // zero vector
        send_beat(make_beat(CMD_ROTATE, 1234, -4321, 999, -77, Q_MAX, 0, 0, 0));
        // first pass clamps
        send_beat(make_beat(CMD_ROTATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                            Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        // conjugate of the most negative value
        send_beat(make_beat(CMD_ROTATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                            Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_beat(make_beat(CMD_ROTATE, 0, 0, 0, Q_MIN, 0, Q_ONE, Q_ONE, Q_ONE));
        // zero quaternion against a full-scale vector
        send_beat(make_beat(CMD_ROTATE, 0, 0, 0, 0, 0, Q_MAX, Q_MIN, Q_MAX));
        // tiny rotor, rounding in both passes
        send_beat(make_beat(CMD_ROTATE, 2, -1, 1, 3, 0, Q_MAX, -Q_ONE, 4097));
    endtask

    // sender holds off until the pipe is empty, then restarts
    task automatic test_drain_pause();
        for (int n = 0; n < 40; n++)
            send_beat(random_beat());
        wait_for_drain();
        for (int n = 0; n < 40; n++)
            send_beat(random_beat());
        wait_for_drain();
    endtask

    // back to back beats, no idling on either side
    task automatic test_no_idle_burst();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int n = 0; n < 300; n++)
            send_beat(random_beat());
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 1500; n++) begin
            send_beat(random_beat());
            if (n % 500 == 499)
                wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_product();
        test_directed_rotate();
        test_drain_pause();
        test_no_idle_burst();
        test_random_mix();

        wait_for_drain();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/qmr_pkg.sv
rtl/qmr_mul.sv
rtl/qmr_sum.sv
rtl/quaternion_multiply_rotate.sv
bench/testbench.sv
